// ===== hw/rtl/aou_pkg.sv =====
// ----------------------------------------------------------------------------
// Azimuth offset unwrap package
// Shared widths, the azimuth type and the output saturation function.
// ----------------------------------------------------------------------------
package aou_pkg;

  // Field widths fixed by the interface.
  localparam int AZ_WIDTH     = 32;
  localparam int OFFSET_WIDTH = 17;
  // Width of the unsaturated sum of an azimuth and a step correction.
  localparam int WIDE_WIDTH   = AZ_WIDTH + 2;

  typedef logic signed [AZ_WIDTH-1:0]     azimuth_t;
  typedef logic signed [OFFSET_WIDTH-1:0] offset_t;
  typedef logic signed [WIDE_WIDTH-1:0]   wide_t;

  localparam wide_t AZ_MAX = wide_t'({1'b0, {(AZ_WIDTH-1){1'b1}}});
  localparam wide_t AZ_MIN = -AZ_MAX - wide_t'(1);

  // Clamp a wide sum to the signed azimuth range.
  function automatic azimuth_t sat_azimuth(input wide_t value);
    azimuth_t clamped;
    if (value > AZ_MAX) begin
      clamped = AZ_MAX[AZ_WIDTH-1:0];
    end else if (value < AZ_MIN) begin
      clamped = AZ_MIN[AZ_WIDTH-1:0];
    end else begin
      clamped = value[AZ_WIDTH-1:0];
    end
    return clamped;
  endfunction

endpackage

// ===== hw/rtl/aou_unwrap.sv =====
// ----------------------------------------------------------------------------
// Azimuth unwrap step
// Combinational unwrap of one wrapped angle against the previous output.
// ----------------------------------------------------------------------------
module aou_unwrap #(
  parameter int FRACTION_BITS = 16
) (
  input  logic [FRACTION_BITS-1:0] cur,
  input  logic                     restart,
  input  aou_pkg::azimuth_t        previous,
  output aou_pkg::azimuth_t        result
);
  import aou_pkg::*;

  // Candidate steps reach nearly three turns either way, so three extra bits.
  localparam int SW = FRACTION_BITS + 3;
  localparam logic signed [SW-1:0] TURN = {{(SW-1){1'b0}}, 1'b1} << FRACTION_BITS;

  logic [FRACTION_BITS-1:0] frac_low;
  logic signed [SW-1:0]     frac;
  logic signed [SW-1:0]     step;
  logic signed [SW-1:0]     cand [4];
  logic [SW-1:0]            mag [4];
  logic signed [SW-1:0]     delta;
  logic [SW-1:0]            best_mag;
  wide_t                    wide_sum;

  // Remainder of the previous output, truncated toward zero so it takes the
  // sign of the previous output.
  assign frac_low = previous[FRACTION_BITS-1:0];
  assign frac = $signed({3'b000, frac_low})
              - ((previous[AZ_WIDTH-1] && (|frac_low)) ? TURN : '0);
  assign step = $signed({3'b000, cur}) - frac;

  // Candidate steps for corrections of 0, +1, -1 and -2 turns.
  assign cand[0] = step;
  assign cand[1] = step + TURN;
  assign cand[2] = step - TURN;
  assign cand[3] = step - (TURN <<< 1);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = cand[i][SW-1] ? SW'(-cand[i]) : SW'(cand[i]);
    end
  end

  // Smallest magnitude wins; on a tie the earlier correction is kept.
  always_comb begin
    delta    = cand[0];
    best_mag = mag[0];
    for (int i = 1; i < 4; i++) begin
      if (mag[i] < best_mag) begin
        best_mag = mag[i];
        delta    = cand[i];
      end
    end
  end

  // The previous output plus the corrected step.
  assign wide_sum = WIDE_WIDTH'(previous) + WIDE_WIDTH'(delta);

  assign result = restart ? azimuth_t'({{(AZ_WIDTH-FRACTION_BITS){1'b0}}, cur})
                          : sat_azimuth(wide_sum);

endmodule

// ===== hw/rtl/azimuth_offset_unwrap_unit.sv =====
// ----------------------------------------------------------------------------
// Azimuth offset unwrap unit
// Adds an offset to azimuth samples, wraps to one turn and unwraps the track.
// ----------------------------------------------------------------------------
// Each accepted sample beat gives one result beat via the input register and
// then the result register; a new sample can be taken every cycle unless the
// result side stalls. The input register holds the offset angle wrapped to
// one turn; the unwrap against the previous output and saturation to 32 bits
// feed the result register combinationally, and the previous output is
// updated at that same edge, the loop that sets the one-sample-per-cycle rate.
// A track_start sample, or the first after reset, is passed on as its wrapped
// value. The offset register has its own valid/ready write port, always ready.
module azimuth_offset_unwrap_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Offset register write port
  input  logic                  offset_valid,
  output logic                  offset_ready,
  input  aou_pkg::offset_t      azimuth_offset,
  // Sample channel
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  aou_pkg::azimuth_t     azimuth_raw,
  input  logic                  track_start,
  // Result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output aou_pkg::azimuth_t     azimuth_unwrapped
);
  import aou_pkg::*;

  offset_t                  offset;
  logic                     s1_valid;
  logic [FRACTION_BITS-1:0] s1_cur;
  logic                     s1_start;
  azimuth_t                 previous_unwrapped;
  logic                     have_previous;

  azimuth_t                 offset_ext;
  logic [FRACTION_BITS-1:0] cur_next;
  logic                     s2_load;
  logic                     s1_advance;
  logic                     restart;
  azimuth_t                 result_next;

  assign offset_ready = 1'b1;

  // Wrap into one turn: only the fraction bits of the sum survive.
  assign offset_ext = AZ_WIDTH'(offset);
  assign cur_next   = azimuth_raw[FRACTION_BITS-1:0] + offset_ext[FRACTION_BITS-1:0];

  // Pipeline flow: the result register loads when empty or being drained.
  assign s2_load      = !result_valid || !result_stall;
  assign s1_advance   = !s1_valid || s2_load;
  assign sample_stall = !s1_advance;

  assign restart = s1_start || !have_previous;

  aou_unwrap #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_unwrap (
    .cur      (s1_cur),
    .restart  (restart),
    .previous (previous_unwrapped),
    .result   (result_next)
  );

  // Control state, offset register and track state.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset             <= '0;
      s1_valid           <= 1'b0;
      result_valid       <= 1'b0;
      previous_unwrapped <= '0;
      have_previous      <= 1'b0;
    end else begin
      if (offset_valid && offset_ready) begin
        offset <= azimuth_offset;
      end
      if (s1_advance) begin
        s1_valid <= sample_valid;
      end
      if (s2_load) begin
        result_valid <= s1_valid;
      end
      if (s2_load && s1_valid) begin
        previous_unwrapped <= result_next;
        have_previous      <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_advance && sample_valid) begin
      s1_cur   <= cur_next;
      s1_start <= track_start;
    end
    if (s2_load && s1_valid) begin
      azimuth_unwrapped <= result_next;
    end
  end

  // A restarted track shows exactly its wrapped angle.
  assert property (@(posedge clk) disable iff (rst)
    (s2_load && s1_valid && restart) |=>
      (azimuth_unwrapped == AZ_WIDTH'($past(s1_cur))))
    else $error("restart beat did not output the wrapped angle");

  // The held result is always the track state used for the next beat.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (previous_unwrapped == azimuth_unwrapped))
    else $error("previous output differs from the held result");

  // Any delivered beat leaves the track state marked as present.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> have_previous)
    else $error("result present without track state");

endmodule

// ===== sim/azimuth_offset_unwrap_unit_test.sv =====
// ----------------------------------------------------------------------------
// Azimuth offset unwrap unit testbench
// Drives azimuth sample beats through the unit under several offset settings,
// predicts each unwrapped result in the testbench and checks every result beat
// in order. It also covers back pressure and sender pauses.
// ----------------------------------------------------------------------------
module azimuth_offset_unwrap_unit_test;
  import aou_pkg::*;

  localparam int     FRACTION_BITS = 16;
  localparam longint TURN          = 64'sd1 << FRACTION_BITS;
  localparam longint OUT_MAX       = 64'sd2147483647;
  localparam longint OUT_MIN       = -64'sd2147483648;
  localparam int     CYCLE_LIMIT   = 1000000;

  logic     clk = 1'b0;
  logic     rst;
  logic     offset_valid;
  logic     offset_ready;
  offset_t  offset_data;
  logic     sample_valid;
  logic     sample_stall;
  azimuth_t azimuth_raw;
  logic     track_start;
  logic     result_valid;
  logic     result_stall = 1'b0;
  azimuth_t azimuth_unwrapped;

  // Predicted unit state and the results still owed by the unit.
  offset_t  offset_setting = '0;
  azimuth_t last_unwrapped = '0;
  logic     have_last      = 1'b0;
  azimuth_t pending_azimuth[$];

  int       error_count  = 0;
  bit       idle_enabled = 1'b1;
  int       hold_request = 0;
  int       hold_left    = 0;
  longint   track_angle  = 0;

  azimuth_offset_unwrap_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .offset_valid     (offset_valid),
    .offset_ready     (offset_ready),
    .azimuth_offset   (offset_data),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .azimuth_raw      (azimuth_raw),
    .track_start      (track_start),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .azimuth_unwrapped(azimuth_unwrapped)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Give up on a hung run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Print one line for a mismatch and count it.
  task automatic report_mismatch(input string msg);
    begin
      if (error_count < 100) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      error_count++;
    end
  endtask

  // Predict the unwrapped azimuth for one accepted sample and advance the
  // predicted state. Integer arithmetic in 64 bits is exact here.
  function automatic azimuth_t unwrap_azimuth(input azimuth_t raw, input logic start);
    longint wrapped;
    longint prev;
    longint whole;
    longint frac;
    longint delta;
    longint best;
    longint best_abs;
    longint cand;
    longint total;
    longint corrections[3];
    corrections = '{TURN, -TURN, -2 * TURN};
    wrapped = (longint'(raw) + longint'(offset_setting)) % TURN;
    if (wrapped < 0) begin
      wrapped += TURN;
    end
    if (start || !have_last) begin
      total = wrapped;
    end else begin
      // Split the last output into whole turns and a same-signed remainder,
      // then take the turn correction that gives the smallest step. The
      // earliest candidate wins a tie.
      prev     = longint'(last_unwrapped);
      whole    = prev / TURN;
      frac     = prev % TURN;
      delta    = wrapped - frac;
      best     = 0;
      best_abs = (delta < 0) ? -delta : delta;
      foreach (corrections[i]) begin
        cand = delta + corrections[i];
        if (cand < 0) begin
          cand = -cand;
        end
        if (cand < best_abs) begin
          best_abs = cand;
          best     = corrections[i];
        end
      end
      total = wrapped + best + whole * TURN;
    end
    if (total > OUT_MAX) begin
      total = OUT_MAX;
    end
    if (total < OUT_MIN) begin
      total = OUT_MIN;
    end
    last_unwrapped = azimuth_t'(total);
    have_last      = 1'b1;
    return azimuth_t'(total);
  endfunction

  // Watch all three channels at the rising edge: check result beats, predict
  // for sample beats and track offset writes.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_azimuth.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with no expected value",
                                    azimuth_unwrapped));
        end else if (azimuth_unwrapped !== pending_azimuth[0]) begin
          report_mismatch($sformatf("azimuth_unwrapped got %0d expected %0d",
                                    azimuth_unwrapped, pending_azimuth[0]));
          void'(pending_azimuth.pop_front());
        end else begin
          void'(pending_azimuth.pop_front());
        end
      end
      if (sample_valid && !sample_stall) begin
        pending_azimuth.push_back(unwrap_azimuth(azimuth_raw, track_start));
      end
      if (offset_valid && offset_ready) begin
        offset_setting = offset_data;
      end
    end
  end

  // Result side stall: random idling, or a counted hold-off when requested.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= idle_enabled && ($urandom_range(0, 99) < 17);
    end
  end

  // Send one sample beat, with an occasional random gap in front of it.
  // Called and returns at a falling edge.
  task automatic send_sample(input azimuth_t raw, input logic start);
    int gap;
    begin
      if (idle_enabled && ($urandom_range(0, 99) < 17)) begin
        gap = $urandom_range(1, 4);
        sample_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      sample_valid <= 1'b1;
      azimuth_raw  <= raw;
      track_start  <= start;
      @(posedge clk);
      while (sample_stall) @(posedge clk);
      @(negedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has arrived.
  task automatic wait_for_results;
    begin
      sample_valid <= 1'b0;
      while (pending_azimuth.size() != 0) @(negedge clk);
      repeat (4) @(negedge clk);
    end
  endtask

  // Write the offset register while the unit is idle.
  task automatic write_offset(input offset_t value);
    begin
      offset_valid <= 1'b1;
      offset_data  <= value;
      @(posedge clk);
      while (!offset_ready) @(posedge clk);
      @(negedge clk);
      offset_valid <= 1'b0;
    end
  endtask

  // Make one random sample: mostly plausible track motion with extra whole
  // turns in the upper bits, plus new tracks, noise, extremes and half-turn
  // steps that land on ties.
  task automatic make_track_sample(output azimuth_t raw, output logic start);
    int     mode;
    longint delta;
    begin
      mode  = $urandom_range(0, 99);
      start = 1'b0;
      if (mode < 4) begin
        start       = 1'b1;
        track_angle = longint'(azimuth_t'($urandom));
        raw         = azimuth_t'(track_angle);
      end else if (mode < 10) begin
        raw         = azimuth_t'($urandom);
        track_angle = longint'(raw);
      end else if (mode < 13) begin
        raw         = $urandom_range(0, 1) ? azimuth_t'(OUT_MAX) : azimuth_t'(OUT_MIN);
        start       = 1'($urandom_range(0, 1));
        track_angle = longint'(raw);
      end else begin
        if (mode < 22) begin
          delta = longint'($urandom_range(32767, 32769));
          if ($urandom_range(0, 1)) begin
            delta = -delta;
          end
        end else if (mode < 60) begin
          delta = longint'($urandom_range(0, 511)) - 256;
        end else begin
          delta = longint'($urandom_range(0, 65535)) - 32768;
        end
        track_angle += delta;
        raw = azimuth_t'(track_angle + longint'($urandom_range(0, 65535)) * TURN);
      end
    end
  endtask

  // Send a run of random samples.
  task automatic send_random_samples(input int count);
    azimuth_t raw;
    logic     start;
    begin
      repeat (count) begin
        make_track_sample(raw, start);
        send_sample(raw, start);
      end
    end
  endtask

  // The first sample after reset starts a track even without track_start.
  task automatic test_first_sample_without_start;
    begin
      send_sample(32'sh0001_2345, 1'b0);
      send_sample(32'sh0001_2400, 1'b0);
    end
  endtask

  // Exact turn multiples wrap to zero; the raw extremes wrap cleanly.
  task automatic test_wrap_boundary_and_extremes;
    begin
      send_sample(azimuth_t'(3 * TURN), 1'b1);
      send_sample(azimuth_t'(-TURN), 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(azimuth_t'(OUT_MIN), 1'b1);
      send_sample(azimuth_t'(OUT_MAX), 1'b0);
      send_sample(32'sd0, 1'b0);
    end
  endtask

  // Steps that need a +1, -1 and -2 turn correction.
  task automatic test_turn_corrections;
    begin
      send_sample(32'sd65000, 1'b1);
      send_sample(32'sd100, 1'b0);
      send_sample(32'sd100, 1'b1);
      send_sample(32'sd65000, 1'b0);
      send_sample(32'sd0, 1'b1);
      send_sample(32'sd40000, 1'b0);
      send_sample(32'sd10000, 1'b0);
      send_sample(32'sd60000, 1'b0);
    end
  endtask

  // Half-turn steps in both directions, from positive and negative outputs,
  // where no correction must win the tie.
  task automatic test_tied_steps;
    begin
      send_sample(32'sd0, 1'b1);
      send_sample(32'sd32768, 1'b0);
      send_sample(32'sd0, 1'b0);
      send_sample(32'sd40000, 1'b0);
      send_sample(32'sd32768, 1'b0);
      send_sample(32'sd0, 1'b0);
    end
  endtask

  // Random tracks under a series of offsets, extremes included. One phase
  // runs with no idling on either side.
  task automatic test_offset_sweep;
    offset_t settings[7];
    begin
      settings = '{17'sd65535, -17'sd65536, offset_t'($urandom), 17'sd1, -17'sd1,
                   offset_t'($urandom), 17'sd0};
      foreach (settings[i]) begin
        wait_for_results();
        write_offset(settings[i]);
        idle_enabled = (i != 2);
        send_random_samples(95);
      end
      idle_enabled = 1'b1;
    end
  endtask

  // Hold the result side off for a long stretch while samples keep coming,
  // so the unit fills up and stalls its input.
  task automatic test_result_backpressure;
    begin
      idle_enabled = 1'b0;
      hold_request = 60;
      send_random_samples(40);
      idle_enabled = 1'b1;
    end
  endtask

  // The sender pauses in the middle of a track until all results are out.
  task automatic test_sender_pause;
    begin
      send_random_samples(10);
      wait_for_results();
      send_random_samples(10);
    end
  endtask

  // Reset, run every test in turn, drain and report.
  initial begin
    rst          = 1'b1;
    offset_valid = 1'b0;
    offset_data  = '0;
    sample_valid = 1'b0;
    azimuth_raw  = '0;
    track_start  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_first_sample_without_start();
    test_wrap_boundary_and_extremes();
    test_turn_corrections();
    test_tied_steps();
    test_offset_sweep();
    test_result_backpressure();
    test_sender_pause();

    wait_for_results();
    if (pending_azimuth.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_azimuth.size()));
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== azimuth_offset_unwrap_unit.f =====
hw/rtl/aou_pkg.sv
hw/rtl/aou_unwrap.sv
hw/rtl/azimuth_offset_unwrap_unit.sv
sim/azimuth_offset_unwrap_unit_test.sv
